// ===== rtl/core/bmss_pkg.sv =====
`default_nettype none
package bmss_pkg;
  localparam int unsigned CharW = 7;
  localparam int unsigned Alphabet = 128;
  localparam int unsigned SkipW = 4;
  localparam int unsigned LenW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 28;
  localparam int unsigned PosW = 10;

  localparam logic [CfgIdxW-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHARS_LOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CHARS_HIGH = 2'd2;

  typedef logic [CharW-1:0] char_t;
  typedef logic [SkipW-1:0] skip_t;
endpackage
`default_nettype wire

// ===== rtl/core/bmss_tables.sv =====
`default_nettype none
// Skip table builder. Bad-character table: one entry preset to m per cycle, then one
// pattern character per cycle. Good-suffix table: one (j, s) trial per cycle.
module bmss_tables #(
  parameter int unsigned PATTERN_MAX = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [$clog2(PATTERN_MAX+1)-1:0]     m,
  input  wire bmss_pkg::char_t                      pat [PATTERN_MAX],
  output logic                                      done,
  input  wire bmss_pkg::char_t                      bc_addr,
  output bmss_pkg::skip_t                           bc_data,
  input  wire logic [$clog2(PATTERN_MAX)-1:0]       gs_addr,
  output bmss_pkg::skip_t                           gs_data
);
  import bmss_pkg::*;
  localparam int unsigned MW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned JW = $clog2(PATTERN_MAX);

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_FILL, S_GS, S_DONE} state_t;
  state_t state;

  skip_t bc_mem [Alphabet];
  skip_t gs_reg [PATTERN_MAX];
  logic [CharW-1:0] cnt;
  logic [MW-1:0] j, s;

  // trial for shift s at position j
  logic ok;
  always_comb begin
    ok = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i > int'(j) && i < int'(m) && i - int'(s) >= 0)
        if (pat[i] != pat[JW'(i - int'(s))]) ok = 1'b0;
    end
    if (int'(j) - int'(s) >= 0)
      if (pat[JW'(int'(j) - int'(s))] == pat[j[JW-1:0]]) ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CLR;
            cnt <= '0;
          end
        end
        S_CLR: begin
          bc_mem[cnt] <= SkipW'(m);
          cnt <= cnt + 1'b1;
          if (cnt == CharW'(Alphabet - 1)) begin
            state <= S_FILL;
            j <= '0;
          end
        end
        S_FILL: begin
          bc_mem[pat[j[JW-1:0]]] <= SkipW'(m - j - 1'b1);
          if (j == m - 1'b1) begin
            state <= S_GS;
            j <= '0;
            s <= MW'(1);
          end else begin
            j <= j + 1'b1;
          end
        end
        S_GS: begin
          if (ok || s == m) begin
            gs_reg[j[JW-1:0]] <= SkipW'(m - 1'b1 - j + s);
            s <= MW'(1);
            if (j == m - 1'b1) state <= S_DONE;
            else j <= j + 1'b1;
          end else begin
            s <= s + 1'b1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bc_data <= bc_mem[bc_addr];
  end
  assign gs_data = gs_reg[gs_addr];
endmodule
`default_nettype wire

// ===== rtl/core/boyer_moore_substring_search_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake      | Payload
// cfg     | in        | valid/ready    | cfg_index, cfg_data
// text    | in        | valid/stall    | text_char, is_last
// result  | out       | valid/stall    | found, match_position, text_overflow
//
// A plain character is stored in text memory. The marked last one starts the table build:
// preset the bad-character table, enter the pattern, then run the good-suffix trials.
// The scan reads text memory for each compared character, and for each shift reads the
// bad-character table and then repeats the window test.
// Reset (rst, synchronous) clears control and the pattern characters and sets the pattern
// length to one; text memory is never cleared. The result waits in an output register while stalled.
module boyer_moore_substring_search_unit #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned TEXT_MAX = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bmss_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bmss_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                        text_valid,
  output logic                             text_stall,
  input  wire bmss_pkg::char_t             text_char,
  input  wire logic                        is_last,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             found,
  output logic [bmss_pkg::PosW-1:0]        match_position,
  output logic                             text_overflow
);
  import bmss_pkg::*;
  localparam int unsigned AW = $clog2(TEXT_MAX);
  localparam int unsigned CW = $clog2(TEXT_MAX + 1);
  localparam int unsigned MW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned JW = $clog2(PATTERN_MAX);

  typedef enum logic [2:0] {S_LOAD, S_BUILD, S_STEP, S_READ, S_CMP, S_SKIP, S_OUT} state_t;
  state_t state;

  logic [LenW-1:0] pattern_length;
  logic [CfgDataW-1:0] chars_low, chars_high;
  char_t pat [PATTERN_MAX];
  logic [MW-1:0] m;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat[i] = (i < 4) ? chars_low[7*(i%4) +: 7] : chars_high[7*(i%4) +: 7];
    end
    if (pattern_length == '0) m = MW'(1);
    else if (32'(pattern_length) > PATTERN_MAX) m = MW'(PATTERN_MAX);
    else m = MW'(pattern_length);
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LenW'(1);
      chars_low <= '0;
      chars_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LenW-1:0];
        REG_CHARS_LOW: chars_low <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // text memory
  char_t text_mem [TEXT_MAX];
  char_t text_rd;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic ovf;
  always_ff @(posedge clk) begin
    if (state == S_LOAD && text_valid && count < CW'(TEXT_MAX))
      text_mem[count[AW-1:0]] <= text_char;
    text_rd <= text_mem[rd_addr];
  end

  logic tb_start, tb_done;
  skip_t bc_data, gs_data;
  logic [JW-1:0] j;
  bmss_tables #(.PATTERN_MAX(PATTERN_MAX)) u_tables (
    .clk(clk), .rst(rst), .start(tb_start), .m(m), .pat(pat), .done(tb_done),
    .bc_addr(text_rd), .bc_data(bc_data), .gs_addr(j), .gs_data(gs_data)
  );

  // scan position k; skip from last mismatch
  logic [CW:0] k;
  skip_t skip;
  skip_t skip_max;
  assign skip_max = (bc_data > gs_data) ? bc_data : gs_data;
  assign text_stall = (state != S_LOAD);
  assign tb_start = (state == S_LOAD) && text_valid && is_last;
  assign rd_addr = k[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (text_valid) begin
            if (count < CW'(TEXT_MAX)) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (is_last) begin
              if (count >= CW'(TEXT_MAX)) ovf <= 1'b1;
              state <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (tb_done) begin
            k <= '0;
            skip <= SkipW'(m - 1'b1);
            state <= S_STEP;
          end
        end
        S_STEP: begin
          // window test: skip <= n-1-k
          if ({1'b0, k} + (CW+2)'(skip) + 1'b1 <= (CW+2)'(count)) begin
            k <= k + (CW+1)'(skip);
            j <= JW'(m - 1'b1);
            state <= S_READ;
          end else begin
            found <= 1'b0;
            match_position <= '0;
            text_overflow <= ovf;
            result_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (pat[j] == text_rd) begin
            if (j == '0) begin
              found <= 1'b1;
              match_position <= PosW'(k);
              text_overflow <= ovf;
              result_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              j <= j - 1'b1;
              k <= k - 1'b1;
              state <= S_READ;
            end
          end else begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // bad-character entry for the mismatched character is now valid
          skip <= skip_max;
          state <= S_STEP;
        end
        S_OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            count <= '0;
            ovf <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
  import bmss_pkg::*;

  typedef struct packed {
    logic             found;
    logic [PosW-1:0]  pos;
    logic             ovf;
  } search_result_t;

  localparam int unsigned TextCap = 1024;
  localparam int unsigned ItemTarget = 1850;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                text_valid;
  logic                text_stall;
  char_t               text_char;
  logic                is_last;
  logic                result_valid;
  logic                result_stall;
  logic                found;
  logic [PosW-1:0]     match_position;
  logic                text_overflow;

  boyer_moore_substring_search_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .text_valid(text_valid), .text_stall(text_stall),
    .text_char(text_char), .is_last(is_last),
    .result_valid(result_valid), .result_stall(result_stall),
    .found(found), .match_position(match_position),
    .text_overflow(text_overflow)
  );

  // Shadow copy of the pattern registers and of the text buffer.
  logic [3:0]          pat_len_reg;
  logic [CfgDataW-1:0] pat_lo_reg;
  logic [CfgDataW-1:0] pat_hi_reg;
  char_t               stored_text[$];
  bit                  text_dropped;

  search_result_t      pending_results[$];
  int                  mismatches;
  int                  chars_sent;
  int                  texts_sent;
  int                  hits_seen;
  int                  max_gap;
  int                  max_stall;
  int                  stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #(4 * 3_000_000);
    $display("boyer_moore_substring_search_unit regression: fail");
    $finish;
  end

  function automatic char_t pattern_char(int i);
    return (i < 4) ? char_t'(pat_lo_reg[7*i +: 7]) : char_t'(pat_hi_reg[7*(i-4) +: 7]);
  endfunction

  function automatic int effective_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > 8) return 8;
    return int'(pat_len_reg);
  endfunction

  // Build the skip tables and run the leftmost Boyer-Moore scan over the
  // shadow text.
  function automatic search_result_t predict_search();
    int m, n, k, skip, j, a, b, s, i, c, pos;
    char_t p[8];
    int bad[128];
    int gs[8];
    bit ok;
    search_result_t r;
    m = effective_len();
    for (i = 0; i < 8; i++) p[i] = pattern_char(i);
    for (c = 0; c < 128; c++) bad[c] = m;
    for (i = 0; i < m; i++) bad[p[i]] = m - 1 - i;
    for (j = 0; j < m; j++) begin
      for (s = 1; s <= m; s++) begin
        ok = 1'b1;
        for (i = j + 1; i < m && ok; i++)
          if (i - s >= 0 && p[i] != p[i-s]) ok = 1'b0;
        if (ok && j - s >= 0 && p[j-s] == p[j]) ok = 1'b0;
        if (ok) break;
      end
      gs[j] = m - 1 - j + s;
    end
    n = stored_text.size();
    pos = -1;
    k = 0;
    skip = m - 1;
    while (skip <= (n - 1) - k) begin
      k += skip;
      j = m - 1;
      while (p[j] == stored_text[k]) begin
        if (j == 0) begin
          pos = k;
          break;
        end
        j--;
        k--;
      end
      if (pos >= 0) break;
      a = bad[stored_text[k]];
      b = gs[j];
      skip = (a > b) ? a : b;
    end
    r.found = (pos >= 0);
    r.pos = (pos >= 0) ? PosW'(pos) : '0;
    r.ovf = text_dropped;
    return r;
  endfunction

  function automatic int draw_wait(int limit);
    return (limit == 0) ? 0 : int'($urandom_range(limit, 0));
  endfunction

  // Result side: check each transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0d pos=%0d ovf=%0d",
                     found, match_position, text_overflow);
        end else begin
          search_result_t exp_r;
          exp_r = pending_results.pop_front();
          if (exp_r.found) hits_seen++;
          if (found !== exp_r.found || match_position !== exp_r.pos ||
              text_overflow !== exp_r.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found=%0d pos=%0d ovf=%0d, got %0d %0d %0d",
                       exp_r.found, exp_r.pos, exp_r.ovf,
                       found, match_position, text_overflow);
          end
        end
        stall_left = draw_wait(max_stall);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      result_stall <= (stall_left > 0);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH: pat_len_reg = value[3:0];
      REG_CHARS_LOW:      pat_lo_reg = value;
      REG_CHARS_HIGH:     pat_hi_reg = value;
      default: ;
    endcase
  endtask

  // Send one character; hold valid high across back-to-back transfers.
  task automatic send_char(char_t c, bit last);
    int gap;
    gap = draw_wait(max_gap);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_char <= c;
    is_last <= last;
    do @(posedge clk); while (text_stall);
    chars_sent++;
    if (stored_text.size() < TextCap) stored_text.push_back(c);
    else text_dropped = 1'b1;
    if (last) begin
      pending_results.push_back(predict_search());
      stored_text.delete();
      text_dropped = 1'b0;
      texts_sent++;
    end
  endtask

  task automatic drain();
    text_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pattern(logic [3:0] len, char_t pc[8]);
    logic [CfgDataW-1:0] lo, hi;
    for (int i = 0; i < 4; i++) begin
      lo[7*i +: 7] = pc[i];
      hi[7*i +: 7] = pc[i+4];
    end
    write_reg(REG_CHARS_LOW, lo);
    write_reg(REG_CHARS_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, {24'($urandom_range(16777215, 0)), len});
  endtask

  // Send a text of len characters over a small alphabet, planting the
  // pattern at plant_at when that is not negative.
  task automatic send_text(int len, int plant_at, bit wide);
    char_t c;
    int m;
    m = effective_len();
    for (int i = 0; i < len; i++) begin
      if (plant_at >= 0 && i >= plant_at && i < plant_at + m)
        c = pattern_char(i - plant_at);
      else if (wide)
        c = char_t'($urandom);
      else
        c = char_t'(97 + $urandom_range(2, 0));
      send_char(c, i == len - 1);
    end
  endtask

  // Reset pattern is a single zero character.
  task automatic test_reset_pattern();
    send_char(7'd5, 1'b0);
    send_char(7'd0, 1'b0);
    send_char(7'd127, 1'b1);
    drain();
  endtask

  task automatic test_directed();
    char_t pc[8];
    // Full-length pattern of all-ones characters, matched at the tail.
    for (int i = 0; i < 8; i++) pc[i] = 7'd127;
    set_pattern(4'd8, pc);
    send_text(10, 2, 1'b0);
    // Pattern longer than the text: not found.
    send_text(5, -1, 1'b0);
    drain();
    // Length zero acts as one; length above eight saturates.
    for (int i = 0; i < 8; i++) pc[i] = char_t'(97 + i);
    set_pattern(4'd0, pc);
    send_text(1, 0, 1'b0);
    drain();
    set_pattern(4'd15, pc);
    send_text(12, 3, 1'b0);
    drain();
    // Out-of-range register index is ignored.
    write_reg(2'd3, '1);
    send_text(8, 0, 1'b0);
    drain();
  endtask

  // Buffer full: tail characters, the last one included, are dropped.
  task automatic test_overflow();
    char_t pc[8];
    for (int i = 0; i < 8; i++) pc[i] = char_t'(120 + ($urandom_range(1, 0) ? i : 0));
    set_pattern(4'd3, pc);
    max_gap = 1;
    send_text(1030, 1000, 1'b0);
    drain();
    max_gap = 16;
  endtask

  task automatic test_random();
    char_t pc[8];
    int texts, len, roll;
    while (chars_sent < ItemTarget) begin
      // Mostly short patterns over the same small alphabet as the text.
      roll = $urandom_range(9, 0);
      for (int i = 0; i < 8; i++)
        pc[i] = (roll == 0) ? char_t'($urandom) : char_t'(97 + $urandom_range(2, 0));
      set_pattern((roll == 1) ? 4'($urandom) : 4'($urandom_range(8, 1)), pc);
      // Alternate between full-rate and heavily idled phases.
      max_gap = ($urandom_range(3, 0) == 0) ? 0 : 16;
      max_stall = ($urandom_range(3, 0) == 0) ? 0 : 16;
      texts = $urandom_range(6, 2);
      for (int t = 0; t < texts; t++) begin
        len = $urandom_range(40, 1);
        send_text(len, ($urandom_range(4, 0) < 3) ? int'($urandom_range(len - 1, 0)) : -1,
                  roll == 0 || $urandom_range(7, 0) == 0);
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    text_valid = 1'b0;
    text_char = '0;
    is_last = 1'b0;
    result_stall = 1'b0;
    pat_len_reg = 4'd1;
    pat_lo_reg = '0;
    pat_hi_reg = '0;
    text_dropped = 1'b0;
    mismatches = 0;
    chars_sent = 0;
    texts_sent = 0;
    hits_seen = 0;
    max_gap = 16;
    max_stall = 16;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_pattern();
    test_directed();
    test_overflow();
    test_random();

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d characters in %0d texts, %0d matches found,", chars_sent,
             texts_sent, hits_seen);
    $display("pattern lengths 0..15, one overflowed text, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("boyer_moore_substring_search_unit regression: pass");
    else
      $display("boyer_moore_substring_search_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
